@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/tpcu_pkg.sv @@
// ----------------------------------------------------------------------------
// Tracker pattern cell unpacker package
// Constants and types shared by the cell unpacker.
// ----------------------------------------------------------------------------
package tpcu_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned FieldCount = 5;

   typedef logic [ByteWidth-1:0]  byte_type;
   typedef logic [FieldCount-1:0] field_mask_type;

   localparam byte_type       LeadMaskThreshold = 8'd128;
   localparam byte_type       FullFormFlags     = 8'hFF;
   localparam field_mask_type BitNote           = 5'h01;
   localparam field_mask_type BitInstrument     = 5'h02;
   localparam field_mask_type BitVolume         = 5'h04;
   localparam field_mask_type BitEffectKind     = 5'h08;
   localparam field_mask_type BitEffectArgument = 5'h10;
   localparam field_mask_type FullFormPending   =
      BitInstrument | BitVolume | BitEffectKind | BitEffectArgument;

   typedef struct packed {
      byte_type flags;
      byte_type note;
      byte_type instrument;
      byte_type volume;
      byte_type effect_kind;
      byte_type effect_argument;
   } cell_type;

endpackage

@@ rtl/core/tracker_pattern_cell_unpacker_top.sv @@
// ----------------------------------------------------------------------------
// Tracker pattern cell unpacker
// Decodes a packed tracker pattern byte stream into one cell per completed
// cell.
// ----------------------------------------------------------------------------
// The block takes one packed pattern byte per cycle unless a byte that
// completes a cell waits in the input register behind a stalled output.
// Each byte is captured in an input register, decoded against the held cell
// state in a single pass, and the finished cell lands in the output
// register. A byte that completes no cell leaves the input register in the
// next cycle even while a cell waits at the output, so bytes are taken
// while the output stalls until one that completes a cell arrives. Absent
// fields repeat the previous cell; pattern start clears held values first.
`include "assert_macros.svh"

module tracker_pattern_cell_unpacker_top
   import tpcu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  byte_type req_data_byte,
   input  logic     req_pattern_start,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output byte_type rsp_cell_flags,
   output byte_type rsp_note_value,
   output byte_type rsp_instrument_number,
   output byte_type rsp_volume_value,
   output byte_type rsp_effect_kind,
   output byte_type rsp_effect_argument
);

   logic           in_valid_ff;
   byte_type       in_byte_ff;
   logic           in_start_ff;
   field_mask_type pending_ff;
   field_mask_type pending_in;
   cell_type       held_ff;
   cell_type       held_in;
   logic           emit;
   logic           advance;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   cell_type       rsp_cell_ff;
   cell_type       cleared;

   assign advance   = in_valid_ff && (!emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      cleared = held_ff;
      if (in_start_ff) begin
         cleared.note            = '0;
         cleared.instrument      = '0;
         cleared.volume          = '0;
         cleared.effect_kind     = '0;
         cleared.effect_argument = '0;
      end
   end

   always_comb begin
      held_in    = cleared;
      pending_in = in_start_ff ? '0 : pending_ff;
      emit       = 1'b0;
      if (pending_in == '0) begin
         if (in_byte_ff < LeadMaskThreshold) begin
            held_in.note  = in_byte_ff;
            held_in.flags = FullFormFlags;
            pending_in    = FullFormPending;
         end else begin
            held_in.flags = in_byte_ff;
            pending_in    = in_byte_ff[FieldCount-1:0];
            emit          = (pending_in == '0);
         end
      end else begin
         priority if (pending_in[0]) begin
            held_in.note = in_byte_ff;
            pending_in   = pending_in & ~BitNote;
         end else if (pending_in[1]) begin
            held_in.instrument = in_byte_ff;
            pending_in         = pending_in & ~BitInstrument;
         end else if (pending_in[2]) begin
            held_in.volume = in_byte_ff;
            pending_in     = pending_in & ~BitVolume;
         end else if (pending_in[3]) begin
            held_in.effect_kind = in_byte_ff;
            pending_in          = pending_in & ~BitEffectKind;
         end else begin
            held_in.effect_argument = in_byte_ff;
            pending_in              = '0;
         end
         emit = (pending_in == '0);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pending_ff   <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            pending_ff <= pending_in;
            held_ff    <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_pattern_start;
      end
      if (advance && emit) begin
         rsp_cell_ff <= held_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_cell_flags        = rsp_cell_ff.flags;
   assign rsp_note_value        = rsp_cell_ff.note;
   assign rsp_instrument_number = rsp_cell_ff.instrument;
   assign rsp_volume_value      = rsp_cell_ff.volume;
   assign rsp_effect_kind       = rsp_cell_ff.effect_kind;
   assign rsp_effect_argument   = rsp_cell_ff.effect_argument;

   `ASSERT_CLKD(a_pending_in_flags, clock, reset, (pending_ff & ~held_ff.flags[FieldCount-1:0]) == '0, "Pending fields are not a subset of the cell flags.")
   `ASSERT_CLKD(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_ff), "Stalled cell changed.")
   `ASSERT_CLKD(a_emit_lands, clock, reset, advance && emit |=> rsp_valid_ff, "Completed cell did not reach the output register.")

endmodule

@@ test/tracker_pattern_cell_unpacker_top_tb.sv @@
// ----------------------------------------------------------------------------
// Tracker pattern cell unpacker testbench
// Sends packed pattern bytes into the unpacker and checks every decoded cell
// against a cycle-free model of the decoder or a cell given by the table.
// The table covers empty and full masks, upper mask bits, the full form at
// both note extremes and a pattern start in the middle of a cell. Random cell
// sequences with noise and broken cells follow; both sides stall at random.
// ----------------------------------------------------------------------------
module tracker_pattern_cell_unpacker_top_tb;
   import tpcu_pkg::*;

   localparam int TotalBytes = 1950;
   localparam int StallLimit = 2000;
   localparam int DirectedCount = 25;

   typedef struct packed {
      byte_type data;
      logic     start;
      logic     typed;
      cell_type row_cell;
   } stim_row;

   localparam stim_row DirectedRows [DirectedCount] = '{
      '{8'h80, 1'b1, 1'b1, 48'h80_00_00_00_00_00},
      '{8'hE0, 1'b0, 1'b1, 48'hE0_00_00_00_00_00},
      '{8'h7F, 1'b0, 1'b0, 48'h0},
      '{8'hFF, 1'b0, 1'b0, 48'h0},
      '{8'h00, 1'b0, 1'b0, 48'h0},
      '{8'hFF, 1'b0, 1'b0, 48'h0},
      '{8'h5A, 1'b0, 1'b1, 48'hFF_7F_FF_00_FF_5A},
      '{8'hFF, 1'b0, 1'b0, 48'h0},
      '{8'hAA, 1'b0, 1'b0, 48'h0},
      '{8'h55, 1'b0, 1'b0, 48'h0},
      '{8'h80, 1'b0, 1'b0, 48'h0},
      '{8'h01, 1'b0, 1'b0, 48'h0},
      '{8'hFE, 1'b0, 1'b1, 48'hFF_AA_55_80_01_FE},
      '{8'h81, 1'b0, 1'b0, 48'h0},
      '{8'h33, 1'b0, 1'b0, 48'h0},
      '{8'h90, 1'b0, 1'b0, 48'h0},
      '{8'hC3, 1'b0, 1'b0, 48'h0},
      '{8'h9F, 1'b0, 1'b0, 48'h0},
      '{8'h11, 1'b0, 1'b0, 48'h0},
      '{8'h80, 1'b1, 1'b1, 48'h80_00_00_00_00_00},
      '{8'h00, 1'b0, 1'b0, 48'h0},
      '{8'h00, 1'b0, 1'b0, 48'h0},
      '{8'h00, 1'b0, 1'b0, 48'h0},
      '{8'h00, 1'b0, 1'b0, 48'h0},
      '{8'h00, 1'b0, 1'b1, 48'hFF_00_00_00_00_00}
   };

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_ready;
   byte_type req_data_byte;
   logic     req_pattern_start;
   logic     rsp_valid;
   logic     rsp_ready;
   byte_type rsp_cell_flags;
   byte_type rsp_note_value;
   byte_type rsp_instrument_number;
   byte_type rsp_volume_value;
   byte_type rsp_effect_kind;
   byte_type rsp_effect_argument;

   field_mask_type fields_todo;
   byte_type       current_flags;
   cell_type       held_cell;
   cell_type       pending_cells[$];
   int             mismatches;
   int             bytes_sent;
   int             quiet_left;
   int             idle_cycles;

   tracker_pattern_cell_unpacker_top u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data_byte         (req_data_byte),
      .req_pattern_start     (req_pattern_start),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_cell_flags        (rsp_cell_flags),
      .rsp_note_value        (rsp_note_value),
      .rsp_instrument_number (rsp_instrument_number),
      .rsp_volume_value      (rsp_volume_value),
      .rsp_effect_kind       (rsp_effect_kind),
      .rsp_effect_argument   (rsp_effect_argument)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic bit decode_byte(input byte_type data, input logic start,
                                      output cell_type out_cell);
      if (start) begin
         held_cell = '0;
         fields_todo = '0;
      end
      out_cell = '0;
      if (fields_todo == '0) begin
         if (data < LeadMaskThreshold) begin
            held_cell.note = data;
            current_flags = FullFormFlags;
            fields_todo = FullFormPending;
            return 1'b0;
         end
         current_flags = data;
         fields_todo = data[FieldCount-1:0];
      end else if ((fields_todo & BitNote) != '0) begin
         held_cell.note = data;
         fields_todo = fields_todo & ~BitNote;
      end else if ((fields_todo & BitInstrument) != '0) begin
         held_cell.instrument = data;
         fields_todo = fields_todo & ~BitInstrument;
      end else if ((fields_todo & BitVolume) != '0) begin
         held_cell.volume = data;
         fields_todo = fields_todo & ~BitVolume;
      end else if ((fields_todo & BitEffectKind) != '0) begin
         held_cell.effect_kind = data;
         fields_todo = fields_todo & ~BitEffectKind;
      end else begin
         held_cell.effect_argument = data;
         fields_todo = '0;
      end
      if (fields_todo != '0) begin
         return 1'b0;
      end
      out_cell = held_cell;
      out_cell.flags = current_flags;
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(input byte_type data, input logic start,
                            input logic typed, input cell_type typed_cell);
      int gap;
      cell_type dec_cell;
      if (quiet_left > 0) begin
         quiet_left--;
         gap = 0;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 99) == 0) begin
            quiet_left = $urandom_range(40, 160);
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_pattern_start <= start;
      do @(posedge clock); while (!req_ready);
      if (decode_byte(data, start, dec_cell)) begin
         pending_cells.push_back(typed ? typed_cell : dec_cell);
      end
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic byte_type field_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return 8'h00;
      end else if (r == 1) begin
         return 8'hFF;
      end
      return byte_type'($urandom_range(0, 255));
   endfunction

   task automatic send_random_cell();
      byte_type lead;
      int count;
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         lead = byte_type'($urandom_range(0, 127));
         count = 4;
      end else if (r < 90) begin
         lead = byte_type'(8'h80 | $urandom_range(0, 127));
         count = $countones(lead[FieldCount-1:0]);
      end else begin
         count = $urandom_range(1, 3);
         repeat (count) begin
            send_byte(byte_type'($urandom_range(0, 255)),
                      logic'($urandom_range(0, 3) == 0), 1'b0, '0);
         end
         return;
      end
      send_byte(lead, logic'($urandom_range(0, 19) == 0), 1'b0, '0);
      repeat (count) begin
         send_byte(field_byte(), logic'($urandom_range(0, 39) == 0), 1'b0, '0);
      end
   endtask

   initial begin
      int n;
      int m;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
         m = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         rsp_ready <= 1'b1;
         repeat (n) @(negedge clock);
         rsp_ready <= 1'b0;
         repeat (m) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      cell_type got;
      cell_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_cell_flags, rsp_note_value, rsp_instrument_number,
                rsp_volume_value, rsp_effect_kind, rsp_effect_argument};
         if (pending_cells.size() == 0) begin
            if (mismatches < 10) begin
               $display("Unexpected cell: flags %h note %h instr %h vol %h fx %h arg %h",
                        got.flags, got.note, got.instrument, got.volume,
                        got.effect_kind, got.effect_argument);
            end
            mismatches++;
         end else begin
            want = pending_cells.pop_front();
            if (got !== want) begin
               if (mismatches < 10) begin
                  $display("Cell mismatch: expected flags %h note %h instr %h vol %h fx %h arg %h",
                           want.flags, want.note, want.instrument, want.volume,
                           want.effect_kind, want.effect_argument);
                  $display("                 actual flags %h note %h instr %h vol %h fx %h arg %h",
                           got.flags, got.note, got.instrument, got.volume,
                           got.effect_kind, got.effect_argument);
               end
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_pattern_start = 1'b0;
      fields_todo = '0;
      current_flags = '0;
      held_cell = '0;
      mismatches = 0;
      bytes_sent = 0;
      quiet_left = 0;
      idle_cycles = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int i = 0; i < DirectedCount; i++) begin
         send_byte(DirectedRows[i].data, DirectedRows[i].start,
                   DirectedRows[i].typed, DirectedRows[i].row_cell);
      end
      while (bytes_sent < TotalBytes) begin
         send_random_cell();
      end
      req_valid <= 1'b0;
      while (pending_cells.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ tracker_pattern_cell_unpacker_top.f @@
+incdir+rtl/core
rtl/core/tpcu_pkg.sv
rtl/core/tracker_pattern_cell_unpacker_top.sv
test/tracker_pattern_cell_unpacker_top_tb.sv
